// ===== rtl/core/fractional_n_synth_divider_calc_macros.svh =====
// assertion helpers for the rtl core
`ifndef FRACTIONAL_N_SYNTH_DIVIDER_CALC_MACROS_SVH
`define FRACTIONAL_N_SYNTH_DIVIDER_CALC_MACROS_SVH

// same-cycle implication
`define FNSD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fnsd check failed");

// next-cycle implication
`define FNSD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fnsd check failed");

`endif

// ===== rtl/core/fnsd_pkg.sv =====
package fnsd_pkg;

  localparam int LO_W   = 33;
  localparam int NUM_W  = 56;  // vco shifted up by up to 23 bits
  localparam int Q_W    = 32;
  localparam int REM_W  = 26;
  localparam int CNT_W  = 6;
  localparam int M_W    = 16;
  localparam int STEP_W = 20;

  // divider thresholds, 2.7 GHz halved four times
  localparam logic [LO_W-1:0] THR0 = 33'd2700000000;
  localparam logic [LO_W-1:0] THR1 = 33'd1350000000;
  localparam logic [LO_W-1:0] THR2 = 33'd675000000;
  localparam logic [LO_W-1:0] THR3 = 33'd337500000;
  localparam logic [LO_W-1:0] THR4 = 33'd168750000;

  localparam logic [LO_W-1:0]   PRESC_SWITCH_HZ = 33'd3200000000;
  localparam logic [REM_W-1:0]  REF_HZ          = 26'd40000000;
  localparam logic [STEP_W-1:0] STEP_HZ         = 20'd625000;
  localparam logic [LO_W-1:0]   TUNED_MAX       = {LO_W{1'b1}};

  localparam logic [1:0] PRESC_LOW  = 2'd1;
  localparam logic [1:0] PRESC_HIGH = 2'd2;
  localparam logic [1:0] LEAK_LOW   = 2'd2;
  localparam logic [1:0] LEAK_HIGH  = 2'd3;
  localparam logic [2:0] DIV_LOG_MAX = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_ROUND,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/core/fractional_n_synth_divider_calc.sv =====
// from input transfer to out_tvalid an item passes setup, 56 divide steps, the done flag,
// round and emit; emit waits while the output register still holds an untaken result
// a new request is taken only in idle, once the bit-serial divide and emit are through
// the output register holds a finished result while the next request is taken
// reset (rst_n low, synchronous) clears the state machine, the divider flags and out_tvalid
`include "fractional_n_synth_divider_calc_macros.svh"

module fractional_n_synth_divider_calc (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [32:0] lo_hz
  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] lo_div_log, [4:3] presc_log, [6:5] cp_leak_code, [12:7] int_n,
  // [28:13] frac_msb, [61:29] tuned_hz
  output logic [63:0] out_tdata
);

  fnsd_pkg::state_t state_r, state_nxt;

  logic [fnsd_pkg::LO_W-1:0]  lo_r;
  logic [2:0]                 dlog_r;
  logic [1:0]                 plog_r;
  logic [1:0]                 leak_r;
  logic [fnsd_pkg::M_W-1:0]   m_r;
  logic [21:0]                word_hi_r;  // rounded word bits 29..8

  logic                       out_tvalid_r;
  logic [63:0]                out_tdata_r;

  logic                       in_xfer;
  logic                       div_start;
  logic                       out_load;
  logic [fnsd_pkg::Q_W-1:0]   quot;
  fnsd_pkg::div_stat_t        div_stat;

  // setup path
  logic [2:0]                 dlog_c;
  logic [37:0]                vco_w;
  logic [fnsd_pkg::LO_W-1:0]  vco;
  logic                       vco_high;
  logic [fnsd_pkg::NUM_W-1:0] num_c;

  // round path
  logic [4:0]                 dshift;
  logic [fnsd_pkg::Q_W-1:0]   half;
  logic [fnsd_pkg::Q_W-1:0]   sum;
  logic [fnsd_pkg::Q_W-1:0]   word;
  logic [fnsd_pkg::Q_W-1:0]   m_w;

  // emit path
  logic [35:0]                prod;
  logic [fnsd_pkg::LO_W-1:0]  tuned;

  assign dlog_c = 3'(lo_r <= fnsd_pkg::THR0) + 3'(lo_r <= fnsd_pkg::THR1)
                + 3'(lo_r <= fnsd_pkg::THR2) + 3'(lo_r <= fnsd_pkg::THR3)
                + 3'(lo_r <= fnsd_pkg::THR4);
  assign vco_w    = {5'b0, lo_r} << dlog_c;
  assign vco      = vco_w[fnsd_pkg::LO_W-1:0];
  assign vco_high = vco > fnsd_pkg::PRESC_SWITCH_HZ;
  assign num_c    = vco_high ? {23'b0, vco} << 22 : {23'b0, vco} << 23;

  // rounding step is 2^(18 - plog + dlog)
  assign dshift = 5'd18 - {3'b0, plog_r} + {2'b0, dlog_r};
  assign half   = fnsd_pkg::Q_W'(1) << (dshift - 5'd1);
  assign sum    = quot + half;
  assign word   = sum & ~((fnsd_pkg::Q_W'(1) << dshift) - fnsd_pkg::Q_W'(1));
  assign m_w    = sum >> dshift;

  // tuned = m * 40 MHz / 64
  assign prod  = {20'b0, m_r} * {16'b0, fnsd_pkg::STEP_HZ};
  assign tuned = (|prod[35:33]) ? fnsd_pkg::TUNED_MAX : prod[32:0];

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      fnsd_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) state_nxt = fnsd_pkg::ST_SETUP;
      end
      fnsd_pkg::ST_SETUP: begin
        div_start = 1'b1;
        state_nxt = fnsd_pkg::ST_DIV;
      end
      fnsd_pkg::ST_DIV: begin
        if (div_stat.done) state_nxt = fnsd_pkg::ST_ROUND;
      end
      fnsd_pkg::ST_ROUND: begin
        state_nxt = fnsd_pkg::ST_EMIT;
      end
      fnsd_pkg::ST_EMIT: begin
        if (!out_tvalid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = fnsd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fnsd_pkg::ST_IDLE;
    endcase
  end

  assign in_xfer = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= fnsd_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_xfer) lo_r <= in_tdata[fnsd_pkg::LO_W-1:0];
    if (div_start) begin
      dlog_r <= dlog_c;
      plog_r <= vco_high ? fnsd_pkg::PRESC_HIGH : fnsd_pkg::PRESC_LOW;
      leak_r <= vco_high ? fnsd_pkg::LEAK_HIGH : fnsd_pkg::LEAK_LOW;
    end
    if (state_r == fnsd_pkg::ST_ROUND) begin
      m_r       <= m_w[fnsd_pkg::M_W-1:0];
      word_hi_r <= word[29:8];
    end
    if (out_load) begin
      // int_n sits below frac_msb
      out_tdata_r <= {2'b0, tuned, word_hi_r[15:0], word_hi_r[21:16], leak_r, plog_r, dlog_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)          out_tvalid_r <= 1'b0;
    else if (out_load)   out_tvalid_r <= 1'b1;
    else if (out_tready) out_tvalid_r <= 1'b0;
  end

  fnsd_serdiv u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_c),
    .quot  (quot),
    .stat  (div_stat)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `FNSD_ASSERT_IMP(a_done_in_div, div_stat.done, state_r == fnsd_pkg::ST_DIV)
  `FNSD_ASSERT_IMP(a_busy_while_div, state_r == fnsd_pkg::ST_DIV && !div_stat.done,
                   div_stat.busy)
  `FNSD_ASSERT_IMP(a_presc_leak_pair, out_tvalid_r,
                   (out_tdata_r[4:3] == fnsd_pkg::PRESC_HIGH) ==
                   (out_tdata_r[6:5] == fnsd_pkg::LEAK_HIGH))
  `FNSD_ASSERT_IMP(a_div_log_range, out_tvalid_r, out_tdata_r[2:0] <= fnsd_pkg::DIV_LOG_MAX)
  `FNSD_ASSERT_NXT(a_load_sets_valid, out_load, out_tvalid_r)

endmodule

// ===== rtl/core/fnsd_serdiv.sv =====
// restoring divider by the reference frequency, one quotient bit per cycle
module fnsd_serdiv (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [fnsd_pkg::NUM_W-1:0]    num,
  output logic [fnsd_pkg::Q_W-1:0]      quot,
  output fnsd_pkg::div_stat_t           stat
);

  logic [fnsd_pkg::NUM_W-1:0] num_r, num_nxt;
  logic [fnsd_pkg::REM_W-1:0] rem_r, rem_nxt;
  logic [fnsd_pkg::Q_W-1:0]   q_r, q_nxt;
  logic [fnsd_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [fnsd_pkg::REM_W:0]   trial;
  logic                       fits;

  assign trial = {rem_r, num_r[fnsd_pkg::NUM_W-1]};
  assign fits  = trial >= {1'b0, fnsd_pkg::REF_HZ};

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt  = num;
      rem_nxt  = '0;
      q_nxt    = '0;
      cnt_nxt  = fnsd_pkg::CNT_W'(fnsd_pkg::NUM_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[fnsd_pkg::NUM_W-2:0], 1'b0};
      // remainder stays below the reference, so the low bits suffice
      rem_nxt = fits ? trial[fnsd_pkg::REM_W-1:0] - fnsd_pkg::REF_HZ
                     : trial[fnsd_pkg::REM_W-1:0];
      q_nxt   = {q_r[fnsd_pkg::Q_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quot      = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
